FILE: rtl/slx_pkg.sv
// Shared types, character codes and class functions for the s-expression lexer.
// Used by every module under rtl; depends on nothing.
package slx_pkg;

    localparam int SLX_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HOLD,
        MODE_STRING,
        MODE_COMMENT
    } mode_t;

    typedef enum logic [2:0] {
        KIND_OPEN,
        KIND_CLOSE,
        KIND_QUOTE,
        KIND_STRING,
        KIND_SYMBOL,
        KIND_DOT
    } kind_t;

    typedef struct packed {
        logic        unterminated;
        logic        token_end;
        logic        token_start;
        kind_t       token_kind;
        logic [7:0]  token_char;
    } result_t;

    // One accepted byte's worth of results; r1 used only when two is set.
    typedef struct packed {
        logic    two;
        result_t r1;
        result_t r0;
    } entry_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_LF) || (b == CH_TAB) || (b == CH_CR);
    endfunction

    function automatic logic is_sym(input logic [7:0] b);
        logic r;
        case (b) inside
            ["A":"Z"], ["a":"z"], ["0":"9"],
            "!", "?", "#", "$", "%", "&", "=", "~", "^", "[", "]", "{",
            "}", "<", ">", ".", "_", "*", "/", "+", "-": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic result_t mk_result(input logic [7:0] ch, input kind_t kind,
                                          input logic st, input logic en,
                                          input logic unt);
        result_t r;
        r.token_char   = ch;
        r.token_kind   = kind;
        r.token_start  = st;
        r.token_end    = en;
        r.unterminated = unt;
        return r;
    endfunction

endpackage

FILE: rtl/slx_front.sv
// Front end: accepts text bytes, runs the lexer state and builds result entries.
// Depends on slx_pkg.
module slx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] text_byte
    input  logic              q_full,
    output logic              q_push,
    output slx_pkg::entry_t   q_entry
);
    import slx_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_dot_reg, held_dot_next;
    logic       held_start_reg, held_start_next;
    logic       accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_char_reg  <= held_char_next;
            held_dot_reg   <= held_dot_next;
            held_start_reg <= held_start_next;
        end
    end

    always_comb begin
        logic [7:0] b;
        logic       idle_work;
        logic       n0;
        logic       iv;
        result_t    ir;
        b               = s_tdata;
        idle_work       = 1'b0;
        n0              = 1'b0;
        iv              = 1'b0;
        ir              = mk_result(b, KIND_OPEN, 1'b1, 1'b1, 1'b0);
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_dot_next   = held_dot_reg;
        held_start_next = held_start_reg;
        q_entry         = '0;

        unique case (mode_reg)
            MODE_STRING: begin
                n0 = 1'b1;
                if (b == CH_DQUOTE) begin
                    q_entry.r0 = mk_result(b, KIND_STRING, 1'b0, 1'b1, 1'b0);
                    mode_next  = MODE_IDLE;
                end else if (b == CH_NUL) begin
                    q_entry.r0 = mk_result(CH_NUL, KIND_STRING, 1'b0, 1'b1, 1'b1);
                    mode_next  = MODE_IDLE;
                end else begin
                    q_entry.r0 = mk_result(b, KIND_STRING, 1'b0, 1'b0, 1'b0);
                end
            end
            MODE_COMMENT: begin
                if (b == CH_LF || b == CH_NUL) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_HOLD: begin
                n0 = 1'b1;
                if (held_dot_reg && is_space(b)) begin
                    q_entry.r0 = mk_result(held_char_reg, KIND_DOT, 1'b1, 1'b1, 1'b0);
                    mode_next  = MODE_IDLE;
                end else if (is_sym(b)) begin
                    q_entry.r0 = mk_result(held_char_reg, KIND_SYMBOL, held_start_reg,
                                           1'b0, 1'b0);
                    held_char_next  = b;
                    held_dot_next   = 1'b0;
                    held_start_next = 1'b0;
                end else begin
                    q_entry.r0 = mk_result(held_char_reg, KIND_SYMBOL, held_start_reg,
                                           1'b1, 1'b0);
                    mode_next  = MODE_IDLE;
                    idle_work  = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                idle_work = 1'b1;
            end
        endcase

        if (idle_work) begin
            if (b == CH_LPAREN) begin
                iv = 1'b1;
                ir = mk_result(b, KIND_OPEN, 1'b1, 1'b1, 1'b0);
            end else if (b == CH_RPAREN) begin
                iv = 1'b1;
                ir = mk_result(b, KIND_CLOSE, 1'b1, 1'b1, 1'b0);
            end else if (b == CH_SQUOTE) begin
                iv = 1'b1;
                ir = mk_result(b, KIND_QUOTE, 1'b1, 1'b1, 1'b0);
            end else if (b == CH_DQUOTE) begin
                iv        = 1'b1;
                ir        = mk_result(b, KIND_STRING, 1'b1, 1'b0, 1'b0);
                mode_next = MODE_STRING;
            end else if (b == CH_SEMI) begin
                mode_next = MODE_COMMENT;
            end else if (is_sym(b)) begin
                mode_next       = MODE_HOLD;
                held_char_next  = b;
                held_dot_next   = (b == CH_DOT);
                held_start_next = 1'b1;
            end
        end

        if (iv) begin
            if (n0) begin
                q_entry.r1  = ir;
                q_entry.two = 1'b1;
            end else begin
                q_entry.r0 = ir;
            end
        end

        q_push = accept && (n0 || iv);
    end

endmodule

FILE: rtl/slx_fifo.sv
// Short entry queue between the lexer front end and the output serializer.
// Depends on slx_pkg.
module slx_fifo #(
    parameter int DEPTH = slx_pkg::SLX_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  slx_pkg::entry_t  push_entry,
    input  logic             pop,
    output slx_pkg::entry_t  head_entry,
    output logic             full,
    output logic             empty
);
    import slx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/slx_back.sv
// Back end: drains queue entries onto the result stream, one result per transfer.
// Depends on slx_pkg.
module slx_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  slx_pkg::entry_t  head_entry,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [7:0] token_char, [8] token_start,
                                        // [9] token_end, [10] unterminated
    output logic [2:0]       m_tuser,   // [2:0] token_kind
    output logic             m_tlast    // run_last
);
    import slx_pkg::*;

    logic    slot_reg, slot_next;
    logic    fire;
    logic    last;
    result_t cur;

    assign m_tvalid = !q_empty;
    assign fire     = m_tvalid && m_tready;
    assign cur      = slot_reg ? head_entry.r1 : head_entry.r0;
    assign last     = slot_reg || !head_entry.two;
    assign q_pop    = fire && last;

    assign m_tdata = {5'b0, cur.unterminated, cur.token_end, cur.token_start, cur.token_char};
    assign m_tuser = cur.token_kind;
    assign m_tlast = last;

    always_comb begin
        slot_next = slot_reg;
        if (fire) begin
            slot_next = !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 1'b0;
        end else begin
            slot_reg <= slot_next;
        end
    end

endmodule

FILE: rtl/lisp_token_lexer.sv
// A paren, quote or string byte's result is written to the entry queue when the byte is
// accepted and is offered on the result stream behind any queued results; a symbol or dot
// byte waits for the byte after it. Throughput: one text byte per cycle while the queue is
// not full; a byte that closes a held symbol and opens a paren, quote or string token gives
// two results in one entry, which the entry queue (QUEUE_DEPTH entries) absorbs until full.
// Reset (aresetn low, synchronous): lexer idle, queue empty, no held byte.
module lisp_token_lexer #(
    parameter int QUEUE_DEPTH = slx_pkg::SLX_QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [7:0] token_char, [8] token_start,
                                    // [9] token_end, [10] unterminated
    output logic [2:0]   m_tuser,   // [2:0] token_kind
    output logic         m_tlast    // run_last
);
    import slx_pkg::*;

    entry_t push_entry;
    entry_t head_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    slx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    slx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    slx_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue overflow");

    a_pair_first_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && push_entry.two) |-> (push_entry.r0.token_end &&
            push_entry.r0.token_kind == KIND_SYMBOL && push_entry.r1.token_start))
        else $error("two-result entry without closed symbol first");

    a_unterminated_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[9] && !m_tdata[8] &&
            m_tuser == KIND_STRING && m_tlast))
        else $error("bad unterminated string mark");

endmodule
